>>> rtl/core/dmps_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmps_pkg
// Shared widths, row kinds and the issue-to-update control bundle.
// ----------------------------------------------------------------------------
package dmps_pkg;

    localparam int VALUE_W = 15;
    localparam int SUM_W   = 23;
    localparam int CFG_W   = 8;

    localparam logic [CFG_W-1:0] HALF_RESET = CFG_W'(1);

    typedef enum logic [1:0] {
        KIND_TOP,
        KIND_UPPER,
        KIND_LOWER
    } row_kind_t;

    typedef struct packed {
        row_kind_t kind;
        logic      first_col;
        logic      last_col;
        logic      row_end;
        logic      grid_end;
    } dmps_ctl_t;

endpackage

>>> rtl/core/dmps_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmps_if
// Valid/ready stream interfaces for cell items and result items.
// ----------------------------------------------------------------------------
interface dmps_cell_if
    import dmps_pkg::*;
;
    logic               valid;
    logic               ready;
    logic [VALUE_W-1:0] cell_value;

    modport source (output valid, output cell_value, input ready);
    modport sink   (input valid, input cell_value, output ready);
endinterface

interface dmps_sum_if
    import dmps_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [SUM_W-1:0] best_sum;

    modport source (output valid, output best_sum, input ready);
    modport sink   (input valid, input best_sum, output ready);
endinterface

>>> rtl/core/dmps_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmps_ram
// Generic single-write, single-read RAM with registered read (read-old).
// ----------------------------------------------------------------------------
module dmps_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic                                   re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> rtl/core/dmps_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmps_seq
// Row/column sequencer: places each accepted cell, issues the parent reads
// and holds the cell for the update stage.
// ----------------------------------------------------------------------------
module dmps_seq
    import dmps_pkg::*;
#(
    parameter int MAX_HALF = 128
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic [CFG_W-1:0]                              half_size,
    input  logic                                          accept,
    input  logic                                          go,
    input  logic [VALUE_W-1:0]                            cell_value,
    output logic [(MAX_HALF > 1 ? $clog2(MAX_HALF) : 1)-1:0] rd_addr_a,
    output logic [(MAX_HALF > 1 ? $clog2(MAX_HALF) : 1)-1:0] rd_addr_b,
    output logic                                          s1_valid,
    output dmps_ctl_t                                     s1_ctl,
    output logic [(MAX_HALF > 1 ? $clog2(MAX_HALF) : 1)-1:0] s1_col,
    output logic [(MAX_HALF > 1 ? $clog2(MAX_HALF) : 1)-1:0] s1_col_b,
    output logic [VALUE_W-1:0]                            s1_value
);

    localparam int CW = (MAX_HALF > 1) ? $clog2(MAX_HALF) : 1;
    localparam int NW = $clog2(MAX_HALF + 1);
    localparam int RW = $clog2(2 * MAX_HALF);
    localparam int HW = (NW > CFG_W) ? NW : CFG_W;

    logic [RW-1:0]      row_reg,  row_next;
    logic [CW-1:0]      col_reg,  col_next;
    logic               s1_valid_reg, s1_valid_next;
    dmps_ctl_t          s1_ctl_reg;
    logic [CW-1:0]      s1_col_reg, s1_col_b_reg;
    logic [VALUE_W-1:0] s1_value_reg;

    logic [HW-1:0] hs_ext;
    logic [NW-1:0] n_eff;
    logic [RW-1:0] rows;
    logic [RW-1:0] r;
    logic [RW-1:0] len_wide;
    logic [NW-1:0] len;
    logic [CW-1:0] c;
    logic [NW-1:0] c_inc;
    logic          row_end;
    logic          grid_end;
    dmps_ctl_t     ctl;

    always_comb
    begin
        hs_ext = HW'(half_size);
        if (hs_ext == '0)
        begin
            n_eff = NW'(1);
        end
        else if (hs_ext > HW'(MAX_HALF))
        begin
            n_eff = NW'(MAX_HALF);
        end
        else
        begin
            n_eff = NW'(hs_ext);
        end

        rows = (RW'(n_eff) << 1) - RW'(1);
        r    = (row_reg >= rows) ? '0 : row_reg;
        len_wide = (r < RW'(n_eff)) ? r + RW'(1) : rows - r;
        len  = NW'(len_wide);
        c    = (NW'(col_reg) >= len) ? '0 : col_reg;

        c_inc    = NW'(c) + NW'(1);
        row_end  = (c_inc >= len);
        grid_end = row_end && (r == rows - RW'(1));

        if (r == '0)
        begin
            ctl.kind = KIND_TOP;
        end
        else if (r < RW'(n_eff))
        begin
            ctl.kind = KIND_UPPER;
        end
        else
        begin
            ctl.kind = KIND_LOWER;
        end
        ctl.first_col = (c == '0);
        ctl.last_col  = (RW'(c) == r);
        ctl.row_end   = row_end;
        ctl.grid_end  = grid_end;

        rd_addr_a = c;
        rd_addr_b = (c == CW'(MAX_HALF - 1)) ? c : c + CW'(1);

        row_next = row_reg;
        col_next = col_reg;
        if (cfg_we)
        begin
            row_next = '0;
            col_next = '0;
        end
        else if (accept)
        begin
            if (grid_end)
            begin
                row_next = '0;
                col_next = '0;
            end
            else if (row_end)
            begin
                row_next = r + RW'(1);
                col_next = '0;
            end
            else
            begin
                row_next = r;
                col_next = CW'(c_inc);
            end
        end

        if (accept)
        begin
            s1_valid_next = 1'b1;
        end
        else if (go)
        begin
            s1_valid_next = 1'b0;
        end
        else
        begin
            s1_valid_next = s1_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg      <= '0;
            col_reg      <= '0;
            s1_valid_reg <= 1'b0;
            s1_ctl_reg   <= '0;
        end
        else
        begin
            row_reg      <= row_next;
            col_reg      <= col_next;
            s1_valid_reg <= s1_valid_next;
            if (accept)
            begin
                s1_ctl_reg <= ctl;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_col_reg   <= rd_addr_a;
            s1_col_b_reg <= rd_addr_b;
            s1_value_reg <= cell_value;
        end
    end

    assign s1_valid = s1_valid_reg;
    assign s1_ctl   = s1_ctl_reg;
    assign s1_col   = s1_col_reg;
    assign s1_col_b = s1_col_b_reg;
    assign s1_value = s1_value_reg;

endmodule

>>> rtl/core/dmps_update.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmps_update
// Update stage: picks the better parent, adds the cell and writes the row
// entry back; forwards the last write to a read that overlapped it.
// ----------------------------------------------------------------------------
module dmps_update
    import dmps_pkg::*;
#(
    parameter int MAX_HALF = 128
) (
    input  logic                                          clk,
    input  logic                                          rst_n,
    input  logic                                          cfg_we,
    input  logic                                          go,
    input  dmps_ctl_t                                     ctl,
    input  logic [(MAX_HALF > 1 ? $clog2(MAX_HALF) : 1)-1:0] col,
    input  logic [(MAX_HALF > 1 ? $clog2(MAX_HALF) : 1)-1:0] col_b,
    input  logic [VALUE_W-1:0]                            value,
    input  logic [SUM_W-1:0]                              q_a,
    input  logic [SUM_W-1:0]                              q_b,
    output logic                                          wr_en,
    output logic [(MAX_HALF > 1 ? $clog2(MAX_HALF) : 1)-1:0] wr_addr,
    output logic [SUM_W-1:0]                              sum
);

    localparam int CW = (MAX_HALF > 1) ? $clog2(MAX_HALF) : 1;

    logic [SUM_W-1:0] held_left_reg, held_left_next;
    logic             lw_valid_reg;
    logic [CW-1:0]    lw_addr_reg;
    logic [SUM_W-1:0] lw_data_reg;

    logic [SUM_W-1:0] above;
    logic [SUM_W-1:0] right;
    logic [SUM_W-1:0] v_ext;

    always_comb
    begin
        above = (lw_valid_reg && lw_addr_reg == col)   ? lw_data_reg : q_a;
        right = (lw_valid_reg && lw_addr_reg == col_b) ? lw_data_reg : q_b;
        v_ext = SUM_W'(value);

        case (ctl.kind)
            KIND_UPPER:
            begin
                if (ctl.first_col)
                begin
                    sum = above + v_ext;
                end
                else if (ctl.last_col)
                begin
                    sum = held_left_reg + v_ext;
                end
                else
                begin
                    sum = ((held_left_reg > above) ? held_left_reg : above) + v_ext;
                end
            end
            KIND_LOWER:
            begin
                sum = ((above > right) ? above : right) + v_ext;
            end
            default:
            begin
                sum = v_ext;
            end
        endcase

        held_left_next = held_left_reg;
        if (cfg_we)
        begin
            held_left_next = '0;
        end
        else if (go)
        begin
            if (ctl.row_end)
            begin
                held_left_next = '0;
            end
            else if (ctl.kind == KIND_UPPER)
            begin
                held_left_next = above;
            end
        end
    end

    assign wr_en   = go;
    assign wr_addr = col;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_left_reg <= '0;
            lw_valid_reg  <= 1'b0;
        end
        else
        begin
            held_left_reg <= held_left_next;
            if (go)
            begin
                lw_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go)
        begin
            lw_addr_reg <= col;
            lw_data_reg <= sum;
        end
    end

endmodule

>>> rtl/core/diamond_max_path_sum.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// diamond_max_path_sum
// Maximum top-to-bottom path sum over a diamond grid streamed cell by cell.
// ----------------------------------------------------------------------------
// Usage:
//   cell_in  : cell items in row order, valid/ready, taken when both high.
//   sum_out  : one result item per grid, issued on the bottom cell.
//   cfg_we / cfg_wdata : writes half_size (0 acts as 1, above MAX_HALF is
//   clamped) and restarts the grid; write only while the block is idle.
// Throughput: one cell per cycle while no bottom cell is held in the update
//   stage. A cell reads its parents from the row memory in the cycle it is
//   taken and writes its sum back from the update stage; the last write is
//   forwarded, so back-to-back cells never wait.
// Result: the update stage's sum for the bottom cell is registered to sum_out.
// Reset: half_size returns to 1, counters clear, no memory clearing pass.
// Stall: a waiting result sits in the output register; cells keep flowing
//   until the next bottom cell reaches the update stage, which then holds.
// ----------------------------------------------------------------------------
module diamond_max_path_sum
    import dmps_pkg::*;
#(
    parameter int MAX_HALF = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [CFG_W-1:0]  cfg_wdata,
    dmps_cell_if.sink         cell_in,
    dmps_sum_if.source        sum_out
);

    localparam int CW = (MAX_HALF > 1) ? $clog2(MAX_HALF) : 1;

    logic [CFG_W-1:0] half_size_reg;
    logic             out_valid_reg;
    logic [SUM_W-1:0] out_sum_reg;

    logic             accept;
    logic             go;
    logic [CW-1:0]    rd_addr_a;
    logic [CW-1:0]    rd_addr_b;
    logic             s1_valid;
    dmps_ctl_t        s1_ctl;
    logic [CW-1:0]    s1_col;
    logic [CW-1:0]    s1_col_b;
    logic [VALUE_W-1:0] s1_value;
    logic [SUM_W-1:0] q_a;
    logic [SUM_W-1:0] q_b;
    logic             wr_en;
    logic [CW-1:0]    wr_addr;
    logic [SUM_W-1:0] sum;

    assign go = s1_valid && !(s1_ctl.grid_end && out_valid_reg && !sum_out.ready);
    assign cell_in.ready = !s1_valid || go;
    assign accept = cell_in.valid && cell_in.ready;

    dmps_seq #(
        .MAX_HALF (MAX_HALF)
    ) u_seq (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_we),
        .half_size  (half_size_reg),
        .accept     (accept),
        .go         (go),
        .cell_value (cell_in.cell_value),
        .rd_addr_a  (rd_addr_a),
        .rd_addr_b  (rd_addr_b),
        .s1_valid   (s1_valid),
        .s1_ctl     (s1_ctl),
        .s1_col     (s1_col),
        .s1_col_b   (s1_col_b),
        .s1_value   (s1_value)
    );

    // two copies of the row, one per parent read
    dmps_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_HALF)
    ) u_row_a (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (sum),
        .re    (accept),
        .raddr (rd_addr_a),
        .rdata (q_a)
    );

    dmps_ram #(
        .WIDTH (SUM_W),
        .DEPTH (MAX_HALF)
    ) u_row_b (
        .clk   (clk),
        .we    (wr_en),
        .waddr (wr_addr),
        .wdata (sum),
        .re    (accept),
        .raddr (rd_addr_b),
        .rdata (q_b)
    );

    dmps_update #(
        .MAX_HALF (MAX_HALF)
    ) u_update (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg_we  (cfg_we),
        .go      (go),
        .ctl     (s1_ctl),
        .col     (s1_col),
        .col_b   (s1_col_b),
        .value   (s1_value),
        .q_a     (q_a),
        .q_b     (q_b),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .sum     (sum)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_size_reg <= HALF_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                half_size_reg <= cfg_wdata;
            end
            if (go && s1_ctl.grid_end)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (sum_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (go && s1_ctl.grid_end)
        begin
            out_sum_reg <= sum;
        end
    end

    assign sum_out.valid    = out_valid_reg;
    assign sum_out.best_sum = out_sum_reg;

    a_result_from_bottom: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(go && s1_ctl.grid_end))
        else $error("result raised without a bottom cell");

    a_ready_only_blocked_by_stage: assert property (@(posedge clk) disable iff (!rst_n)
        !cell_in.ready |-> (s1_valid && s1_ctl.grid_end && out_valid_reg))
        else $error("input blocked without a held bottom cell");

    a_write_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> s1_valid)
        else $error("row write without an item in the update stage");

endmodule

>>> tb/dmps_path_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dmps_path_checker
// Watches the cell and sum channels and the half_size write port. It keeps
// its own row of best partial sums and predicts the best path sum of each
// grid. Each result item is compared with the oldest predicted sum.
// ----------------------------------------------------------------------------
module dmps_path_checker
    import dmps_pkg::*;
#(
    parameter int MAX_HALF = 128
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_wdata,
    dmps_cell_if             cell_ch,
    dmps_sum_if              sum_ch,
    output int               mismatches,
    output int               waiting_sums
);

    logic [CFG_W-1:0] half_reg;
    logic [SUM_W-1:0] row_best [MAX_HALF];
    logic [SUM_W-1:0] held_left;
    int unsigned      row_no;
    int unsigned      col_no;
    logic [SUM_W-1:0] best_sums_due [$];
    logic [SUM_W-1:0] due_sum;

    function automatic logic [SUM_W-1:0] larger_of(input logic [SUM_W-1:0] a,
                                                   input logic [SUM_W-1:0] b);
        return (a > b) ? a : b;
    endfunction

    function void restart_grid();
        held_left = '0;
        row_no    = 0;
        col_no    = 0;
    endfunction

    function void take_cell(input logic [VALUE_W-1:0] value);
        int unsigned      n;
        int unsigned      rows;
        int unsigned      len;
        int unsigned      r;
        int unsigned      c;
        int unsigned      right;
        logic [SUM_W-1:0] above;
        logic [SUM_W-1:0] sum;
        n = half_reg;
        if (n == 0)
            n = 1;
        if (n > MAX_HALF)
            n = MAX_HALF;
        rows = 2 * n - 1;
        r    = row_no;
        c    = col_no;
        if (r >= rows)
            r = 0;
        len = (r < n) ? r + 1 : rows - r;
        if (c >= len)
            c = 0;

        if (r == 0)
            sum = SUM_W'(value);
        else if (r < n)
        begin
            above = row_best[c];
            if (c == 0)
                sum = above + SUM_W'(value);
            else if (c == r)
                sum = held_left + SUM_W'(value);
            else
                sum = larger_of(held_left, above) + SUM_W'(value);
            held_left = above;
        end
        else
        begin
            right = c + 1;
            if (right >= MAX_HALF)
                right = MAX_HALF - 1;
            sum = larger_of(row_best[c], row_best[right]) + SUM_W'(value);
        end
        row_best[c] = sum;

        c++;
        if (c >= len)
        begin
            c         = 0;
            held_left = '0;
            r++;
            if (r >= rows)
            begin
                row_no = 0;
                col_no = 0;
                best_sums_due.push_back(sum);
                return;
            end
        end
        row_no = r;
        col_no = c;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            half_reg = HALF_RESET;
            restart_grid();
            foreach (row_best[k])
                row_best[k] = '0;
            best_sums_due.delete();
            mismatches = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                half_reg = cfg_wdata;
                restart_grid();
            end
            if (cell_ch.valid && cell_ch.ready)
                take_cell(cell_ch.cell_value);
            if (sum_ch.valid && sum_ch.ready)
            begin
                if (best_sums_due.size() == 0)
                begin
                    $display("%0t: best_sum expected none, got %0d", $time, sum_ch.best_sum);
                    mismatches++;
                end
                else
                begin
                    due_sum = best_sums_due.pop_front();
                    if (sum_ch.best_sum !== due_sum)
                    begin
                        $display("%0t: best_sum expected %0d, got %0d",
                                 $time, due_sum, sum_ch.best_sum);
                        mismatches++;
                    end
                end
            end
        end
        waiting_sums = best_sums_due.size();
    end

endmodule

>>> tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the diamond path-sum block: directed grids at sizes 0 to 3,
// a grid restart by a mid-grid write, part of a grid after an oversize write,
// then random grid sizes and cell values, with random gaps on the cell side
// and random stalls on the sum side. Checking is done by dmps_path_checker.
// ----------------------------------------------------------------------------
module tb;
    import dmps_pkg::*;

    localparam int      MAX_HALF     = 128;
    localparam int      RANDOM_CELLS = 1350;
    localparam int      WIDE_CELLS   = 300;
    localparam int      DRAIN_CYCLES = 6;
    localparam longint  CYCLE_LIMIT  = 5_000_000;

    logic             clk;
    logic             rst_n;
    logic             cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic             cell_taken;
    int               mismatches;
    int               waiting_sums;
    int unsigned      burst_left;
    int unsigned      random_cells;
    longint unsigned  cycle_count = 0;

    dmps_cell_if cell_if ();
    dmps_sum_if  sum_if ();

    diamond_max_path_sum #(
        .MAX_HALF (MAX_HALF)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cell_in   (cell_if),
        .sum_out   (sum_if)
    );

    dmps_path_checker #(
        .MAX_HALF (MAX_HALF)
    ) path_checker (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_we),
        .cfg_wdata    (cfg_wdata),
        .cell_ch      (cell_if),
        .sum_ch       (sum_if),
        .mismatches   (mismatches),
        .waiting_sums (waiting_sums)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cell_taken <= 1'b0;
        else
            cell_taken <= cell_if.valid && cell_if.ready;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // sum side: ready bursts, short stalls, the odd long stall or long open stretch
    initial
    begin
        int unsigned open_len;
        int unsigned stall_len;
        sum_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            open_len  = ($urandom_range(0, 9) == 0) ? $urandom_range(150, 300)
                                                    : $urandom_range(1, 12);
            stall_len = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 30);
            sum_if.ready <= 1'b1;
            repeat (open_len) @(negedge clk);
            sum_if.ready <= 1'b0;
            repeat (stall_len) @(negedge clk);
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (roll < 55)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else if (roll < 97)
            return $urandom_range(4, 8);
        return $urandom_range(10, 30);
    endfunction

    function automatic logic [VALUE_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2:       return VALUE_W'($urandom_range(0, 3));
            default: return VALUE_W'($urandom_range(0, 32767));
        endcase
    endfunction

    function automatic int unsigned grid_cells(input logic [CFG_W-1:0] half);
        int unsigned n;
        n = half;
        if (n == 0)
            n = 1;
        if (n > MAX_HALF)
            n = MAX_HALF;
        return n * n;
    endfunction

    task automatic send_cell(input logic [VALUE_W-1:0] value);
        int unsigned gap;
        if (burst_left > 0)
        begin
            burst_left--;
            gap = 0;
        end
        else if ($urandom_range(0, 149) == 0)
        begin
            burst_left = $urandom_range(40, 120);
            gap        = 0;
        end
        else
            gap = pick_gap();
        if (gap != 0)
        begin
            cell_if.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        cell_if.valid      <= 1'b1;
        cell_if.cell_value <= value;
        do
            @(negedge clk);
        while (!cell_taken);
    endtask

    task automatic send_cells(input int unsigned count, input bit all_max);
        repeat (count)
            send_cell(all_max ? '1 : pick_value());
    endtask

    // hold the cell side until every predicted sum is out and the block is quiet
    task automatic settle();
        cell_if.valid <= 1'b0;
        while (waiting_sums != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    task automatic write_half(input logic [CFG_W-1:0] half);
        cfg_we    <= 1'b1;
        cfg_wdata <= half;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_W-1:0] half;
        int unsigned      cells;
        int unsigned      roll;
        cell_if.valid      = 1'b0;
        cell_if.cell_value = '0;
        cfg_we             = 1'b0;
        cfg_wdata          = '0;
        rst_n              = 1'b0;
        burst_left         = 0;
        random_cells       = 0;
        repeat (3) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset size: every cell is a whole grid
        send_cell('0);
        send_cell('1);
        send_cell(VALUE_W'(1));

        settle();
        write_half(CFG_W'(2));
        send_cells(4, 1'b1);
        send_cell(VALUE_W'(5));
        send_cell(VALUE_W'(7));
        send_cell(VALUE_W'(7));
        send_cell(VALUE_W'(1));

        // size zero acts as one
        settle();
        write_half('0);
        send_cell(VALUE_W'(15'h5555));
        send_cell(VALUE_W'(15'h2AAA));

        settle();
        write_half(CFG_W'(3));
        send_cell(VALUE_W'(3));
        send_cell('0);
        send_cell('1);
        send_cell(VALUE_W'(1));
        send_cell(VALUE_W'(2));
        send_cell(VALUE_W'(3));
        send_cell('1);
        send_cell('0);
        send_cell(VALUE_W'(9));

        // a write part way through a grid restarts it
        send_cells(4, 1'b0);
        settle();
        write_half(CFG_W'(2));
        send_cells(4, 1'b0);

        // oversize write clamps to the widest size; part of a grid at max values
        settle();
        write_half('1);
        send_cells(WIDE_CELLS, 1'b1);

        while (random_cells < RANDOM_CELLS)
        begin
            settle();
            roll = $urandom_range(0, 19);
            if (roll == 0)
                half = '0;
            else if (roll == 1)
                half = CFG_W'($urandom_range(9, 16));
            else
                half = CFG_W'($urandom_range(1, 8));
            write_half(half);
            cells = grid_cells(half);
            repeat ($urandom_range(1, 5))
            begin
                send_cells(cells, 1'b0);
                random_cells += cells;
            end
            if (cells > 1 && $urandom_range(0, 3) == 0)
            begin
                roll = $urandom_range(1, cells - 1);
                send_cells(roll, 1'b0);
                random_cells += roll;
            end
        end

        settle();
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
